### hdl/alm_pkg.sv
// Shared types, codes and constants of the audio level meter.
package alm_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_CHANNELS = 8;
  localparam int CH_BITS      = 3;
  localparam int XW           = 2 * SAMPLE_BITS;
  localparam int ENERGY_BITS  = 58;
  localparam int CLIPS_BITS   = 13;
  localparam int POWER_BITS   = 48;

  localparam logic [ENERGY_BITS-1:0] ENERGY_CAP = {ENERGY_BITS{1'b1}};
  localparam logic [CLIPS_BITS-1:0]  CLIPS_CAP  = {CLIPS_BITS{1'b1}};
  localparam logic signed [15:0]     RESET_FLOOR = -16'sd30720;
  localparam logic [18:0]            DB_K_Q16 = 19'd394566;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_EOB    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [2:0] REG_DECAY  = 3'd0;
  localparam logic [2:0] REG_HOLD   = 3'd1;
  localparam logic [2:0] REG_ALPHA  = 3'd2;
  localparam logic [2:0] REG_CLIP   = 3'd3;
  localparam logic [2:0] REG_FLOOR  = 3'd4;
  localparam logic [2:0] REG_LEN    = 3'd5;
  localparam logic [2:0] REG_ACTIVE = 3'd6;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [2:0]        out_channel;
    logic signed [15:0] peak_db;
    logic signed [15:0] hold_db;
    logic signed [15:0] rms_db;
    logic              clip_seen;
    logic [23:0]       run_peak;
    logic [31:0]       clip_total;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak;
    logic [ENERGY_BITS-1:0] energy;
    logic [CLIPS_BITS-1:0]  clips;
  } acc_t;

  typedef struct packed {
    logic               rd;
    logic               upd;
    logic               zero;
    logic [CH_BITS-1:0] addr;
  } acc_cmd_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mag;
    logic [XW-1:0]          sq;
    logic                   hit;
  } acc_upd_t;

  typedef struct packed {
    logic signed [15:0]     peak_level;
    logic signed [15:0]     hold_level;
    logic [15:0]            hold_age;
    logic [POWER_BITS-1:0]  mean_power;
    logic                   clip_flag;
    logic [SAMPLE_BITS-1:0] largest_seen;
    logic [31:0]            clip_count;
  } meter_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_S_RD, ST_S_SQ, ST_S_WR,
    ST_W_RD, ST_W_DAT, ST_W_M1, ST_W_M2, ST_W_M3, ST_W_M4,
    ST_W_PK, ST_W_PKW, ST_W_UPD, ST_W_RMSW, ST_W_OUT, ST_W_NEXT
  } top_state_t;

  typedef enum logic [2:0] {
    DB_IDLE, DB_NORM, DB_DIST, DB_MUL, DB_RND, DB_DONE
  } db_state_t;

endpackage

### hdl/alm_db.sv
// Iterative log2 based converter from linear amplitude or power to Q8.8 dBFS.
module alm_db #(
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    power,
  input  logic [alm_pkg::XW-1:0]  x,
  input  logic signed [15:0]      floor_db,
  output logic                    done,
  output logic signed [15:0]      db
);

  localparam int ROM_N = 1 << LOG_TABLE_BITS;
  typedef logic [15:0] rom_t [ROM_N];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] m;
    logic [15:0] frac;
    for (int i = 0; i < ROM_N; i++) begin
      m    = 64'(ROM_N + i) << (30 - LOG_TABLE_BITS);
      frac = '0;
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          frac[b] = 1'b1;
          m       = m >> 1;
        end
      end
      r[i] = frac;
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  alm_pkg::db_state_t state, state_next;
  logic [alm_pkg::XW-1:0] xr;
  logic [5:0]             e;
  logic                   pw;
  logic [21:0]            d;
  logic [40:0]            prod;
  logic signed [15:0]     res;
  logic [21:0]            l;
  logic [21:0]            ref_l;
  logic [41:0]            rnd;
  logic [16:0]            mag_db;
  logic signed [17:0]     neg_db;

  assign l      = {e, 16'b0} + 22'(ROM[xr[alm_pkg::XW-2 -: LOG_TABLE_BITS]]);
  assign ref_l  = pw ? 22'(2 * (alm_pkg::SAMPLE_BITS - 1)) << 16
                     : 22'(alm_pkg::SAMPLE_BITS - 1) << 16;
  assign rnd    = {1'b0, prod} + (pw ? (42'd1 << 24) : (42'd1 << 23));
  assign mag_db = pw ? 17'(rnd >> 25) : 17'(rnd >> 24);
  assign neg_db = -$signed({1'b0, mag_db});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alm_pkg::DB_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      alm_pkg::DB_IDLE: begin
        xr  <= x;
        pw  <= power;
        e   <= 6'(alm_pkg::XW - 1);
        res <= floor_db;
      end
      alm_pkg::DB_NORM: begin
        if (!xr[alm_pkg::XW-1]) begin
          xr <= xr << 1;
          e  <= e - 6'd1;
        end
      end
      alm_pkg::DB_DIST: d <= (l >= ref_l) ? 22'd0 : ref_l - l;
      alm_pkg::DB_MUL:  prod <= 41'(d) * 41'(alm_pkg::DB_K_Q16);
      alm_pkg::DB_RND: begin
        if (neg_db < 18'(floor_db)) begin
          res <= floor_db;
        end else begin
          res <= 16'(neg_db);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      alm_pkg::DB_IDLE: begin
        if (start) begin
          state_next = (x == '0) ? alm_pkg::DB_DONE : alm_pkg::DB_NORM;
        end
      end
      alm_pkg::DB_NORM: if (xr[alm_pkg::XW-1]) state_next = alm_pkg::DB_DIST;
      alm_pkg::DB_DIST: state_next = alm_pkg::DB_MUL;
      alm_pkg::DB_MUL:  state_next = alm_pkg::DB_RND;
      alm_pkg::DB_RND:  state_next = alm_pkg::DB_DONE;
      alm_pkg::DB_DONE: state_next = alm_pkg::DB_IDLE;
      default:          state_next = alm_pkg::DB_IDLE;
    endcase
  end

  assign done = (state == alm_pkg::DB_DONE);
  assign db   = res;

endmodule

### hdl/alm_accum.sv
// Per-channel block accumulator memory with its sample read-modify-write datapath.
module alm_accum (
  input  logic              clk,
  input  alm_pkg::acc_cmd_t cmd,
  input  alm_pkg::acc_upd_t upd,
  output alm_pkg::acc_t     rdata
);

  alm_pkg::acc_t mem [alm_pkg::MAX_CHANNELS];
  alm_pkg::acc_t nxt;
  logic [alm_pkg::ENERGY_BITS:0] room;

  always_comb begin
    nxt  = rdata;
    room = {1'b0, alm_pkg::ENERGY_CAP - rdata.energy};
    if (upd.mag > rdata.peak) nxt.peak = upd.mag;
    if ((alm_pkg::ENERGY_BITS+1)'(upd.sq) >= room) begin
      nxt.energy = alm_pkg::ENERGY_CAP;
    end else begin
      nxt.energy = rdata.energy + alm_pkg::ENERGY_BITS'(upd.sq);
    end
    if (upd.hit && rdata.clips < alm_pkg::CLIPS_CAP) nxt.clips = rdata.clips + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[cmd.addr];
    if (cmd.zero) begin
      mem[cmd.addr] <= '0;
    end else if (cmd.upd) begin
      mem[cmd.addr] <= nxt;
    end
  end

endmodule

### hdl/audio_level_meter_ballistics.sv
// Top level of the audio level meter: control sequencer, meter memory and output register.
// A sample request steps through memory read, magnitude square and write back.
// An end-of-block request walks all 8 channels; an active one runs the mean-power update and
// two dB conversions (one normalizing shift a cycle), an inactive one only clears its accumulators.
// The walk also waits while a finished report sits unaccepted in the output register.
// A clear request, and reset, run a clearing pass over every entry of both memories.
// Reset is synchronous, active high, restores the register defaults and starts that pass.
module audio_level_meter_ballistics #(
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  alm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output alm_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data
);

  // Configuration registers.
  logic [15:0] reg_decay;
  logic [15:0] reg_hold;
  logic [16:0] reg_alpha;
  logic [23:0] reg_clip;
  logic [15:0] reg_floor;
  logic [3:0]  reg_len;
  logic [3:0]  reg_active;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_decay  <= 16'd512;
      reg_hold   <= 16'd30;
      reg_alpha  <= 17'd65536;
      reg_clip   <= 24'd8388608;
      reg_floor  <= 16'(alm_pkg::RESET_FLOOR);
      reg_len    <= 4'd8;
      reg_active <= 4'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        alm_pkg::REG_DECAY:  reg_decay  <= cfg_data[15:0];
        alm_pkg::REG_HOLD:   reg_hold   <= cfg_data[15:0];
        alm_pkg::REG_ALPHA:  reg_alpha  <= cfg_data[16:0];
        alm_pkg::REG_CLIP:   reg_clip   <= cfg_data;
        alm_pkg::REG_FLOOR:  reg_floor  <= cfg_data[15:0];
        alm_pkg::REG_LEN:    reg_len    <= cfg_data[3:0];
        alm_pkg::REG_ACTIVE: reg_active <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective settings after range limiting.
  logic [3:0]         act_n;
  logic [3:0]         len_eff;
  logic [16:0]        alpha_eff;
  logic [16:0]        alpha_inv;
  logic signed [15:0] floor_eff;

  always_comb begin
    act_n = reg_active;
    if (reg_active == 4'd0) act_n = 4'd1;
    if (reg_active > 4'(alm_pkg::MAX_CHANNELS)) act_n = 4'(alm_pkg::MAX_CHANNELS);
    len_eff   = (reg_len > 4'd12) ? 4'd12 : reg_len;
    alpha_eff = (reg_alpha > 17'd65536) ? 17'd65536 : reg_alpha;
    alpha_inv = 17'd65536 - alpha_eff;
    // A floor above 0 dB counts as 0 dB.
    floor_eff = reg_floor[15] ? $signed(reg_floor) : 16'sd0;
  end

  alm_pkg::top_state_t state, state_next;
  alm_pkg::in_t        req;
  logic [3:0]          cnt;      // clearing pass and walk position
  logic [alm_pkg::CH_BITS-1:0] ch_idx;
  logic                wc_active;
  logic                cnt_end;

  assign ch_idx    = cnt[alm_pkg::CH_BITS-1:0];
  assign wc_active = cnt < act_n;
  assign cnt_end   = (cnt == 4'(alm_pkg::MAX_CHANNELS - 1));

  // Accumulator memory and its sample path.
  alm_pkg::acc_cmd_t acc_cmd;
  alm_pkg::acc_upd_t acc_upd;
  alm_pkg::acc_t     acc_rd;
  logic [alm_pkg::SAMPLE_BITS-1:0] mag;
  logic [alm_pkg::XW-1:0]          sq;

  alm_accum u_accum (
    .clk   (clk),
    .cmd   (acc_cmd),
    .upd   (acc_upd),
    .rdata (acc_rd)
  );

  assign acc_upd.mag = mag;
  assign acc_upd.sq  = sq;
  // A zero clip level makes every sample count as clipped.
  assign acc_upd.hit = (mag >= reg_clip);

  // Meter memory, read and written a whole channel at a time.
  alm_pkg::meter_t meter_mem [alm_pkg::MAX_CHANNELS];
  alm_pkg::meter_t mrd;
  alm_pkg::meter_t mnew;
  alm_pkg::meter_t mreset;
  logic            m_rd;
  logic            m_wr;

  always_comb begin
    mreset            = '0;
    mreset.peak_level = alm_pkg::RESET_FLOOR;
    mreset.hold_level = alm_pkg::RESET_FLOOR;
  end

  always_ff @(posedge clk) begin
    if (m_rd) mrd <= meter_mem[ch_idx];
    if (m_wr) meter_mem[ch_idx] <= (state == alm_pkg::ST_CLEAR) ? mreset : mnew;
  end

  // dB converter shared by the block peak and the averaged power.
  logic                   db_start;
  logic                   db_power;
  logic [alm_pkg::XW-1:0] db_x;
  logic                   db_done;
  logic signed [15:0]     db_val;

  alm_db #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_db (
    .clk      (clk),
    .rst      (rst),
    .start    (db_start),
    .power    (db_power),
    .x        (db_x),
    .floor_db (floor_eff),
    .done     (db_done),
    .db       (db_val)
  );

  // Walk datapath.
  logic [46:0]              ms_r;
  logic [49:0]              np_acc;
  logic [alm_pkg::POWER_BITS-1:0] np_cap;
  logic [alm_pkg::ENERGY_BITS-1:0] ms_shift;
  logic signed [15:0]       bp_db;
  logic signed [15:0]       rms_db;
  logic                     out_load;

  localparam logic [49:0] FULL_POW = 50'd1 << (2 * (alm_pkg::SAMPLE_BITS - 1));

  assign ms_shift = acc_rd.energy >> len_eff;
  assign np_cap   = (np_acc > FULL_POW) ? alm_pkg::POWER_BITS'(FULL_POW)
                                        : alm_pkg::POWER_BITS'(np_acc);
  assign db_power = (state != alm_pkg::ST_W_PK);
  assign db_x     = (state == alm_pkg::ST_W_PK) ? alm_pkg::XW'(acc_rd.peak) : np_cap;

  // Peak, hold and counter updates for the channel under the walk.
  logic signed [17:0] step_s, decayed, pk18, bp18, hold18, h18, fl18;
  logic [15:0]        age_inc;

  always_comb begin
    step_s  = $signed({2'b00, reg_decay});
    bp18    = 18'(bp_db);
    hold18  = 18'(mrd.hold_level);
    fl18    = 18'(floor_eff);
    decayed = 18'(mrd.peak_level) - step_s;
    pk18    = (bp18 > decayed) ? bp18 : decayed;
    if (pk18 < fl18) pk18 = fl18;
    h18     = hold18 - step_s;
    age_inc = (mrd.hold_age == 16'hFFFF) ? mrd.hold_age : mrd.hold_age + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (state)
        alm_pkg::ST_IDLE: begin
          req <= in_data;
          cnt <= '0;
        end
        alm_pkg::ST_CLEAR: cnt <= cnt + 4'd1;
        alm_pkg::ST_S_RD: begin
          mag <= req.sample[alm_pkg::SAMPLE_BITS-1] ? (~req.sample) + 1'b1 : req.sample;
        end
        alm_pkg::ST_S_SQ: sq <= alm_pkg::XW'(mag) * alm_pkg::XW'(mag);
        alm_pkg::ST_W_DAT: begin
          ms_r <= (ms_shift > alm_pkg::ENERGY_BITS'(FULL_POW)) ? 47'(FULL_POW)
                                                               : 47'(ms_shift);
        end
        // One-pole average as four Q16 partial products; the two low-half products are rounded half up.
        alm_pkg::ST_W_M1: np_acc <= 50'(mrd.mean_power[47:16]) * 50'(alpha_inv);
        alm_pkg::ST_W_M2: np_acc <= np_acc
                            + 50'((34'(mrd.mean_power[15:0]) * 34'(alpha_inv)
                                   + 34'd32768) >> 16);
        alm_pkg::ST_W_M3: np_acc <= np_acc + 50'(ms_r[46:16]) * 50'(alpha_eff);
        alm_pkg::ST_W_M4: np_acc <= np_acc
                            + 50'((34'(ms_r[15:0]) * 34'(alpha_eff) + 34'd32768) >> 16);
        alm_pkg::ST_W_PKW: if (db_done) bp_db <= db_val;
        alm_pkg::ST_W_UPD: begin
          mnew.peak_level <= 16'(pk18);
          // The hold marker parks when the block peak reaches it.
          if (bp18 >= hold18) begin
            mnew.hold_level <= bp_db;
            mnew.hold_age   <= 16'd0;
          end else begin
            mnew.hold_age <= age_inc;
            if (age_inc > reg_hold) begin
              mnew.hold_level <= (h18 > pk18) ? 16'(h18) : 16'(pk18);
            end else begin
              mnew.hold_level <= mrd.hold_level;
            end
          end
          mnew.mean_power   <= np_cap;
          mnew.clip_flag    <= mrd.clip_flag | (acc_rd.clips != '0);
          mnew.largest_seen <= (acc_rd.peak > mrd.largest_seen) ? acc_rd.peak
                                                                : mrd.largest_seen;
          if (33'(acc_rd.clips) > 33'(32'hFFFF_FFFF - mrd.clip_count)) begin
            mnew.clip_count <= 32'hFFFF_FFFF;
          end else begin
            mnew.clip_count <= mrd.clip_count + 32'(acc_rd.clips);
          end
        end
        alm_pkg::ST_W_RMSW: if (db_done) rms_db <= db_val;
        alm_pkg::ST_W_NEXT: cnt <= cnt + 4'd1;
        default: ;
      endcase
    end
  end

  // Output register: a finished report waits here while the walk moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_channel <= ch_idx;
      out_data.peak_db     <= mnew.peak_level;
      out_data.hold_db     <= mnew.hold_level;
      out_data.rms_db      <= rms_db;
      out_data.clip_seen   <= mnew.clip_flag;
      out_data.run_peak    <= mnew.largest_seen;
      out_data.clip_total  <= mnew.clip_count;
      out_data.last        <= (cnt + 4'd1 == act_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and memory, converter and output controls.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    acc_cmd      = '0;
    acc_cmd.addr = ch_idx;
    m_rd         = 1'b0;
    m_wr         = 1'b0;
    db_start     = 1'b0;
    out_load     = 1'b0;
    case (state)
      alm_pkg::ST_CLEAR: begin
        acc_cmd.zero = 1'b1;
        m_wr         = 1'b1;
        if (cnt_end) state_next = alm_pkg::ST_IDLE;
      end
      alm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.kind)
            alm_pkg::KIND_SAMPLE: begin
              // Samples for channels beyond the active count are dropped.
              if (4'(in_data.channel) < act_n) state_next = alm_pkg::ST_S_RD;
            end
            alm_pkg::KIND_EOB:   state_next = alm_pkg::ST_W_RD;
            alm_pkg::KIND_CLEAR: state_next = alm_pkg::ST_CLEAR;
            default: ;
          endcase
        end
      end
      alm_pkg::ST_S_RD: begin
        acc_cmd.rd   = 1'b1;
        acc_cmd.addr = req.channel;
        state_next   = alm_pkg::ST_S_SQ;
      end
      alm_pkg::ST_S_SQ: begin
        acc_cmd.addr = req.channel;
        state_next   = alm_pkg::ST_S_WR;
      end
      alm_pkg::ST_S_WR: begin
        acc_cmd.upd  = 1'b1;
        acc_cmd.addr = req.channel;
        state_next   = alm_pkg::ST_IDLE;
      end
      alm_pkg::ST_W_RD: begin
        acc_cmd.rd = 1'b1;
        m_rd       = 1'b1;
        state_next = alm_pkg::ST_W_DAT;
      end
      alm_pkg::ST_W_DAT: begin
        // Inactive channels only get their accumulators cleared.
        if (wc_active) begin
          state_next = alm_pkg::ST_W_M1;
        end else begin
          acc_cmd.zero = 1'b1;
          state_next   = alm_pkg::ST_W_NEXT;
        end
      end
      alm_pkg::ST_W_M1: state_next = alm_pkg::ST_W_M2;
      alm_pkg::ST_W_M2: state_next = alm_pkg::ST_W_M3;
      alm_pkg::ST_W_M3: state_next = alm_pkg::ST_W_M4;
      alm_pkg::ST_W_M4: state_next = alm_pkg::ST_W_PK;
      alm_pkg::ST_W_PK: begin
        db_start   = 1'b1;
        state_next = alm_pkg::ST_W_PKW;
      end
      alm_pkg::ST_W_PKW: if (db_done) state_next = alm_pkg::ST_W_UPD;
      alm_pkg::ST_W_UPD: begin
        db_start   = 1'b1;
        state_next = alm_pkg::ST_W_RMSW;
      end
      alm_pkg::ST_W_RMSW: if (db_done) state_next = alm_pkg::ST_W_OUT;
      alm_pkg::ST_W_OUT: begin
        if (!out_valid || out_ready) begin
          out_load     = 1'b1;
          m_wr         = 1'b1;
          acc_cmd.zero = 1'b1;
          state_next   = alm_pkg::ST_W_NEXT;
        end
      end
      alm_pkg::ST_W_NEXT: begin
        state_next = cnt_end ? alm_pkg::ST_IDLE : alm_pkg::ST_W_RD;
      end
      default: state_next = alm_pkg::ST_IDLE;
    endcase
  end

  // A sample write-back lands on the entry read by the same request.
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    acc_cmd.upd |-> $past(acc_cmd.rd, 2) && (acc_cmd.addr == $past(acc_cmd.addr, 2)))
    else $error("accumulator write-back does not match its read");

  // The final report names the last active channel.
  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (4'(out_data.out_channel) + 4'd1 == act_n))
    else $error("last flag on wrong channel");

  // The walk updates meter state only for active channels.
  a_meter_active: assert property (@(posedge clk) disable iff (rst)
    (m_wr && state != alm_pkg::ST_CLEAR) |-> wc_active)
    else $error("meter written for inactive channel");

endmodule

### tb/sv/audio_level_meter_ballistics_test.sv
// Self-checking testbench for the audio level meter: directed and random requests, scored against a built-in predictor.
module audio_level_meter_ballistics_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 300;    // covers a sample or clear still in flight
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall for the back-pressure phase
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Predictor of the meter. It keeps its own copy of the registers and per-channel state,
  // and holds the reports that accepted end-of-block requests are due to produce.
  class level_predictor;
    logic [15:0] decay_step, hold_count, floor_raw;
    logic [16:0] alpha;
    logic [23:0] clip_thresh;
    logic [3:0]  len_log2, chan_count;
    longint unsigned blk_peak[alm_pkg::MAX_CHANNELS], blk_energy[alm_pkg::MAX_CHANNELS];
    int unsigned     blk_clips[alm_pkg::MAX_CHANNELS], age[alm_pkg::MAX_CHANNELS];
    int unsigned     clips_total[alm_pkg::MAX_CHANNELS];
    int              peak_lvl[alm_pkg::MAX_CHANNELS], hold_lvl[alm_pkg::MAX_CHANNELS];
    longint unsigned avg_power[alm_pkg::MAX_CHANNELS], biggest[alm_pkg::MAX_CHANNELS];
    bit              clipped[alm_pkg::MAX_CHANNELS];
    alm_pkg::out_t   expected_reports[$];
    int              mismatches, reports_checked, requests_seen;

    function new();
      decay_step = 16'd512; hold_count = 16'd30; alpha = 17'd65536;
      clip_thresh = 24'd8388608; floor_raw = 16'(alm_pkg::RESET_FLOOR); len_log2 = 4'd8;
      chan_count = 4'd6;
      clear_all();
    endfunction

    function void clear_all();
      for (int c = 0; c < alm_pkg::MAX_CHANNELS; c++) begin
        blk_peak[c] = 0; blk_energy[c] = 0; blk_clips[c] = 0;
        peak_lvl[c] = int'(alm_pkg::RESET_FLOOR); hold_lvl[c] = int'(alm_pkg::RESET_FLOOR);
        age[c] = 0;
        avg_power[c] = 0; clipped[c] = 0; biggest[c] = 0; clips_total[c] = 0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        alm_pkg::REG_DECAY:  decay_step = val[15:0];
        alm_pkg::REG_HOLD:   hold_count = val[15:0];
        alm_pkg::REG_ALPHA:  alpha = val[16:0];
        alm_pkg::REG_CLIP:   clip_thresh = val;
        alm_pkg::REG_FLOOR:  floor_raw = val[15:0];
        alm_pkg::REG_LEN:    len_log2 = val[3:0];
        alm_pkg::REG_ACTIVE: chan_count = val[3:0];
        default: ;
      endcase
    endfunction

    function int active_chans();
      if (chan_count == 0) return 1;
      if (chan_count > alm_pkg::MAX_CHANNELS) return alm_pkg::MAX_CHANNELS;
      return chan_count;
    endfunction

    function int floor_level();
      int f;
      f = int'($signed(floor_raw));
      return (f > 0) ? 0 : f;
    endfunction

    // Fractional log2 table entry, built by repeated squaring of the mantissa.
    function longint unsigned log_frac(int unsigned i);
      longint unsigned m;
      longint unsigned frac;
      m = longint'(64 + (i & 63)) << 24;
      frac = 0;
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          frac |= 64'd1 << b;
          m >>= 1;
        end
      end
      return frac;
    endfunction

    function longint unsigned log2_fixed(longint unsigned x);
      int e;
      longint unsigned idx;
      e = 63;
      while (x[e] == 1'b0) e--;
      if (e < 6) idx = x << (6 - e);
      else idx = x >> (e - 6);
      return (longint'(e) << 16) + log_frac(int'(idx & 63));
    endfunction

    function int to_qdb(longint unsigned x, bit is_power);
      int fl, db;
      longint unsigned full, l, d;
      fl = floor_level();
      if (x == 0) return fl;
      full = is_power ? 64'd46 * 65536 : 64'd23 * 65536;
      l = log2_fixed(x);
      d = (l >= full) ? 0 : full - l;
      if (is_power) db = -int'((d * alm_pkg::DB_K_Q16 + (64'd1 << 24)) >> 25);
      else db = -int'((d * alm_pkg::DB_K_Q16 + (64'd1 << 23)) >> 24);
      return (db < fl) ? fl : db;
    endfunction

    function longint unsigned scale_q16(longint unsigned x, longint unsigned a);
      return (x >> 16) * a + ((((x & 64'hFFFF) * a) + 32768) >> 16);
    endfunction

    function void take_sample(int ch, logic [23:0] raw);
      longint unsigned mag, sq;
      mag = raw[23] ? (64'd1 << 24) - raw : 64'(raw);
      if (mag > blk_peak[ch]) blk_peak[ch] = mag;
      sq = mag * mag;
      if (sq >= 64'(alm_pkg::ENERGY_CAP) - blk_energy[ch])
        blk_energy[ch] = 64'(alm_pkg::ENERGY_CAP);
      else blk_energy[ch] += sq;
      if (mag >= clip_thresh && blk_clips[ch] < 8191) blk_clips[ch]++;
    endfunction

    function void close_channel(int c);
      int fl, step, bp_db, pk, h;
      int unsigned len;
      longint unsigned a, full, ms, np;
      fl = floor_level();
      step = int'(decay_step);
      len = (len_log2 > 12) ? 12 : len_log2;
      a = (alpha > 65536) ? 65536 : alpha;
      full = 64'd1 << 46;
      bp_db = to_qdb(blk_peak[c], 1'b0);
      pk = (bp_db > peak_lvl[c] - step) ? bp_db : peak_lvl[c] - step;
      if (pk < fl) pk = fl;
      peak_lvl[c] = pk;
      // The hold marker parks on a new maximum, otherwise ages and eventually falls.
      if (bp_db >= hold_lvl[c]) begin
        hold_lvl[c] = bp_db;
        age[c] = 0;
      end else begin
        if (age[c] < 65535) age[c]++;
        if (age[c] > hold_count) begin
          h = hold_lvl[c] - step;
          hold_lvl[c] = (h > pk) ? h : pk;
        end
      end
      ms = blk_energy[c] >> len;
      if (ms > full) ms = full;
      np = scale_q16(avg_power[c], 65536 - a) + scale_q16(ms, a);
      if (np > full) np = full;
      avg_power[c] = np;
      if (blk_clips[c] > 0) clipped[c] = 1;
      if (64'(blk_clips[c]) + clips_total[c] > 64'hFFFF_FFFF) clips_total[c] = 32'hFFFF_FFFF;
      else clips_total[c] += blk_clips[c];
      if (blk_peak[c] > biggest[c]) biggest[c] = blk_peak[c];
    endfunction

    // Called for every accepted request.
    function void note_request(alm_pkg::in_t req);
      int n;
      alm_pkg::out_t rep;
      requests_seen++;
      n = active_chans();
      case (req.kind)
        alm_pkg::KIND_SAMPLE: if (req.channel < n) take_sample(req.channel, req.sample);
        alm_pkg::KIND_CLEAR:  clear_all();
        alm_pkg::KIND_EOB: begin
          for (int c = 0; c < n; c++) begin
            close_channel(c);
            rep.out_channel = 3'(c);
            rep.peak_db     = 16'(peak_lvl[c]);
            rep.hold_db     = 16'(hold_lvl[c]);
            rep.rms_db      = 16'(to_qdb(avg_power[c], 1'b1));
            rep.clip_seen   = clipped[c];
            rep.run_peak    = 24'(biggest[c]);
            rep.clip_total  = clips_total[c];
            rep.last        = (c + 1 == n);
            expected_reports.push_back(rep);
          end
          for (int c = 0; c < alm_pkg::MAX_CHANNELS; c++) begin
            blk_peak[c] = 0; blk_energy[c] = 0; blk_clips[c] = 0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH t=%0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_report(alm_pkg::out_t got);
      alm_pkg::out_t want;
      if (expected_reports.size() == 0) begin
        report("unexpected report, channel", got.out_channel, -1);
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      if (got.out_channel != want.out_channel)
        report("out_channel", got.out_channel, want.out_channel);
      if (got.peak_db != want.peak_db) report("peak_db", got.peak_db, want.peak_db);
      if (got.hold_db != want.hold_db) report("hold_db", got.hold_db, want.hold_db);
      if (got.rms_db != want.rms_db) report("rms_db", got.rms_db, want.rms_db);
      if (got.clip_seen != want.clip_seen) report("clip_seen", got.clip_seen, want.clip_seen);
      if (got.run_peak != want.run_peak) report("run_peak", got.run_peak, want.run_peak);
      if (got.clip_total != want.clip_total)
        report("clip_total", got.clip_total, want.clip_total);
      if (got.last != want.last) report("last", got.last, want.last);
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  alm_pkg::in_t  in_data;
  alm_pkg::out_t out_data;
  logic [2:0]    cfg_index;
  logic [23:0]   cfg_data;

  level_predictor meter_model = new();

  // Idle modes: 0 none, 1 sender gaps, 2 receiver stalls, 3 both at a light rate.
  int idle_mode = 0;
  bit pressure_go = 0, pressure_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int random_items = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  audio_level_meter_ballistics u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Receiver side. The long hold-off is counted here, apart from the request sender,
  // which keeps offering samples until the meter backs up and drops in_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      pressure_done = 1;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready <= ($urandom_range(0, 99) >= 56);
    end else if (idle_mode == 3) begin
      out_ready <= ($urandom_range(0, 99) >= 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Report monitor and no-progress watchdog. Values are taken as they stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) meter_model.check_report(out_data);
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d reports outstanding",
                 meter_model.expected_reports.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offers one request; returns at the edge where it is taken. The sender may first
  // go idle for a random stretch, depending on the idle mode.
  task send_request(alm_pkg::in_t req);
    int pct;
    pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 15 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    meter_model.note_request(req);
  endtask

  task send_item(logic [1:0] kind, int ch, logic [23:0] smp);
    alm_pkg::in_t req;
    req.kind = kind;
    req.channel = 3'(ch);
    req.sample = smp;
    send_request(req);
  endtask

  task end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected report has come back, then lets the walk or a trailing
  // sample finish so the meter is idle.
  task drain_reports();
    while (meter_model.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_register(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    meter_model.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task program_meter(int decay, int hold, int alpha_w, int clip, int floor_q, int len, int chans);
    write_register(alm_pkg::REG_DECAY, 24'(decay));
    write_register(alm_pkg::REG_HOLD, 24'(hold));
    write_register(alm_pkg::REG_ALPHA, 24'(alpha_w));
    write_register(alm_pkg::REG_CLIP, 24'(clip));
    write_register(alm_pkg::REG_FLOOR, 24'(16'(floor_q)));
    write_register(alm_pkg::REG_LEN, 24'(len));
    write_register(alm_pkg::REG_ACTIVE, 24'(chans));
  endtask

  // Random sample: full-scale extremes sometimes, otherwise a random value scaled down
  // by a per-block shift so that block peaks rise and fall and exercise the hold marker.
  function logic [23:0] random_sample(int shift);
    int unsigned pick;
    logic [23:0] v;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 24'h800000;
    if (pick == 1) return 24'h7FFFFF;
    if (pick == 2) return 24'h000000;
    v = 24'($urandom) >> shift;
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // One metering block: interleaved samples for the active channels, mostly 2^min(len,2) each,
  // then an end of block. Noise: stray samples on random channels, spare kinds, clears.
  task random_block();
    int n, per, shift;
    n = meter_model.active_chans();
    per = 1 << ((meter_model.len_log2 > 2) ? 2 : meter_model.len_log2);
    if ($urandom_range(0, 4) == 0) per = $urandom_range(0, per + 1);
    shift = $urandom_range(0, 23);
    for (int s = 0; s < per; s++) begin
      for (int c = 0; c < n; c++) begin
        send_item(alm_pkg::KIND_SAMPLE, c, random_sample(shift));
        random_items++;
      end
      if ($urandom_range(0, 9) == 0)
        send_item(alm_pkg::KIND_SAMPLE, $urandom_range(0, 7), 24'($urandom));
    end
    case ($urandom_range(0, 19))
      0: send_item(KIND_SPARE, $urandom_range(0, 7), 24'($urandom));
      1: begin
        send_item(alm_pkg::KIND_CLEAR, $urandom_range(0, 7), 24'($urandom));
        random_items++;
      end
      default: ;
    endcase
    send_item(alm_pkg::KIND_EOB, $urandom_range(0, 7), 24'($urandom));
    random_items++;
  endtask

  task random_phase(int budget);
    int start;
    start = random_items;
    while (random_items - start < budget) random_block();
    end_stream();
    drain_reports();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    repeat (20) @(posedge clk);  // the meter runs its clearing pass after reset

    // Directed part with reset settings: six active channels, block length 256.
    // Extreme samples, an ignored sample on an inactive channel, a spare kind,
    // a short block, a clear and an end of block right after the clear.
    send_item(alm_pkg::KIND_SAMPLE, 0, 24'h800000);
    send_item(alm_pkg::KIND_SAMPLE, 1, 24'h7FFFFF);
    send_item(alm_pkg::KIND_SAMPLE, 2, 24'h000001);
    send_item(alm_pkg::KIND_SAMPLE, 3, 24'hFFFFFF);
    send_item(alm_pkg::KIND_SAMPLE, 4, 24'h000000);
    send_item(alm_pkg::KIND_SAMPLE, 5, 24'h555555);
    send_item(alm_pkg::KIND_SAMPLE, 5, 24'hAAAAAA);
    send_item(alm_pkg::KIND_SAMPLE, 7, 24'h7FFFFF);
    send_item(KIND_SPARE, 7, 24'hFFFFFF);
    send_item(alm_pkg::KIND_EOB, 0, 24'h0);
    send_item(alm_pkg::KIND_SAMPLE, 0, 24'h400000);
    send_item(alm_pkg::KIND_EOB, 0, 24'h0);
    send_item(alm_pkg::KIND_CLEAR, 0, 24'h0);
    send_item(alm_pkg::KIND_EOB, 0, 24'h0);
    send_item(alm_pkg::KIND_SAMPLE, 1, 24'hC00000);
    send_item(alm_pkg::KIND_EOB, 0, 24'h0);
    end_stream();
    drain_reports();

    // Lowest settings: no decay, no hold, frozen average, every sample clipped,
    // zero floor, one-sample blocks, all eight channels.
    program_meter(0, 0, 0, 0, 0, 0, 8);
    idle_mode = 1;
    random_phase(30);

    // Highest settings: longest hold, full weight, lowest floor, longest block, one channel.
    program_meter(65535, 65535, 65536, 8388608, -32768, 12, 1);
    idle_mode = 2;
    random_phase(20);

    // Out-of-range values: weight above one, positive floor, block length above 12,
    // channel count above eight.
    program_meter(1024, 1, 131071, 1, 256, 15, 15);
    idle_mode = 3;
    random_phase(30);

    // Zero channel count, which meters one channel, with a partial weight.
    program_meter(256, 2, 40000, 4000000, -15360, 2, 0);
    idle_mode = 0;
    random_phase(25);

    // Random settings with short blocks; the receiver holds off for a long stretch
    // while samples keep coming, so the meter backs up into its input.
    program_meter($urandom_range(0, 2000), $urandom_range(0, 5), $urandom_range(0, 65536),
                  $urandom_range(1, 8388608), -$urandom_range(0, 32768), $urandom_range(0, 3),
                  $urandom_range(4, 8));
    idle_mode = 1;
    pressure_go = 1;
    random_phase(35);

    program_meter($urandom_range(0, 4000), $urandom_range(0, 3), $urandom_range(0, 131071),
                  $urandom_range(1, 8388608), -$urandom_range(0, 32768), $urandom_range(0, 2),
                  $urandom_range(1, 8));
    idle_mode = 3;
    random_phase(30);

    $display("covered %0d requests and %0d channel reports over seven register settings,",
             meter_model.requests_seen, meter_model.reports_checked);
    $display("including range extremes, out-of-range codes, clears and a long output stall");
    if (meter_model.mismatches == 0 && meter_model.expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
